@@ rtl/flra_pkg.sv @@
// ----------------------------------------------------------------------------
// flra_pkg
// Shared types and constants for the face landmark roll alignment block.
// ----------------------------------------------------------------------------
package flra_pkg;

  localparam int MAX_POINTS = 128;
  localparam int PT_AW      = $clog2(MAX_POINTS);

  localparam int LM_EYE_A = 51;
  localparam int LM_EYE_B = 65;
  localparam int LM_PIVOT = 74;

  localparam logic [15:0] Q14_ONE = 16'd16384;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [0:0] REG_BBOX_COUNT  = 1'b0;
  localparam logic [0:0] REG_POINT_COUNT = 1'b1;

  localparam logic [7:0] BBOX_COUNT_RST  = 8'd106;
  localparam logic [7:0] POINT_COUNT_RST = 8'd118;

  // shared shift/subtract unit
  localparam int DIV_OP_W  = 62;
  localparam int DIV_RES_W = 40;
  localparam int DIV_REM_W = 34;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic        command;
    logic [6:0]  point_index;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
  } item_t;

  typedef struct packed {
    logic [6:0]        out_index;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic              size_error;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic                 sqrt_mode;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_OP_W-1:0]  operand;
    logic [DIV_DEN_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_RES_W-1:0] result;
  } div_stat_t;

endpackage

@@ rtl/face_landmark_roll_align_top.sv @@
// ----------------------------------------------------------------------------
// face_landmark_roll_align_top
// Landmark store, bounding box and roll alignment of one landmark per read.
//
//  channel  direction  handshake                 payload
//  item     in         start & !busy             item_t
//  result   out        done (one-cycle strobe)   result_t
//  config   in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// A load leaves busy low. A read whose square side is zero answers on the
// next cycle without going busy. Any other read holds busy through two
// 33-step divisions in the shared divider and strobes done on the cycle
// after busy ends; the first read after a load also runs the square root
// and the two 45-step divisions that give cos and sin, unless landmarks 51
// and 65 coincide. Reset is synchronous; the result strobe cannot be
// stalled and config is always ready.
// ----------------------------------------------------------------------------
module face_landmark_roll_align_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  flra_pkg::item_t   item,
  output logic              done,
  output flra_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import flra_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_R51  = 5'd1;
  localparam logic [4:0] S_R65  = 5'd2;
  localparam logic [4:0] S_R74  = 5'd3;
  localparam logic [4:0] S_SQ1  = 5'd4;
  localparam logic [4:0] S_SQ2  = 5'd5;
  localparam logic [4:0] S_SQZ  = 5'd6;
  localparam logic [4:0] S_SQW  = 5'd7;
  localparam logic [4:0] S_CS   = 5'd8;
  localparam logic [4:0] S_CW   = 5'd9;
  localparam logic [4:0] S_SS   = 5'd10;
  localparam logic [4:0] S_SW   = 5'd11;
  localparam logic [4:0] S_PT   = 5'd12;
  localparam logic [4:0] S_PD   = 5'd13;
  localparam logic [4:0] S_M1   = 5'd14;
  localparam logic [4:0] S_M2   = 5'd15;
  localparam logic [4:0] S_DXS  = 5'd16;
  localparam logic [4:0] S_DXW  = 5'd17;
  localparam logic [4:0] S_M3   = 5'd18;
  localparam logic [4:0] S_M4   = 5'd19;
  localparam logic [4:0] S_DYS  = 5'd20;
  localparam logic [4:0] S_DYW  = 5'd21;

  logic [4:0]  state;
  logic [4:0]  state_next;

  logic [7:0]  bbox_count;
  logic [7:0]  point_count;
  logic [15:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic signed [15:0] rotation_cos, rotation_sin;
  logic [31:0] pivot_xy;
  logic        rotation_ready;

  logic [6:0]  idx;
  logic [15:0] side;
  logic [15:0] ea_x, ea_y;
  logic signed [16:0] dx, dy, a, b;
  logic [30:0] len;
  logic signed [35:0] acc;
  logic        neg;
  logic signed [15:0] res_x;

  logic        accept;
  logic        in_range;
  logic        widen;
  logic [15:0] base_min_x, base_max_x, base_min_y, base_max_y;
  logic [15:0] wd, ht, side_now;
  logic [PT_AW-1:0] raddr;
  logic [31:0] rdata;
  logic        we;

  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic signed [16:0] base_x, base_y;
  logic [35:0] acc_mag;
  logic [32:0] out_dvd;
  logic [16:0] dx_mag, dy_mag;

  div_cmd_t  dcmd;
  div_stat_t dstat;

  function automatic logic signed [15:0] sat16(input logic n,
                                               input logic [DIV_RES_W-1:0] q);
    logic signed [15:0] v;
    if (n) begin
      v = (q > DIV_RES_W'(32768)) ? 16'sh8000 : 16'(~q[15:0] + 16'd1);
    end else begin
      v = (q > DIV_RES_W'(32767)) ? 16'sh7fff : q[15:0];
    end
    return v;
  endfunction

  assign busy      = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_range  = int'(item.point_index) < MAX_POINTS;
  assign we        = accept && in_range && item.command == CMD_LOAD;

  assign wd       = (box_max_x >= box_min_x) ? box_max_x - box_min_x : 16'd0;
  assign ht       = (box_max_y >= box_min_y) ? box_max_y - box_min_y : 16'd0;
  assign side_now = (wd > ht) ? wd : ht;

  assign base_min_x = (item.point_index == 7'd0) ? 16'hffff : box_min_x;
  assign base_max_x = (item.point_index == 7'd0) ? 16'h0000 : box_max_x;
  assign base_min_y = (item.point_index == 7'd0) ? 16'hffff : box_min_y;
  assign base_max_y = (item.point_index == 7'd0) ? 16'h0000 : box_max_y;
  assign widen      = {1'b0, item.point_index} < bbox_count;

  flra_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (PT_AW'(item.point_index)),
    .wdata ({item.y_coord, item.x_coord}),
    .raddr (raddr),
    .rdata (rdata)
  );

  flra_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (dcmd),
    .stat (dstat)
  );

  always_comb begin
    case (state)
      S_R51:   raddr = PT_AW'(LM_EYE_A);
      S_R65:   raddr = PT_AW'(LM_EYE_B);
      S_R74:   raddr = PT_AW'(LM_PIVOT);
      default: raddr = PT_AW'(idx);
    endcase
  end

  always_comb begin
    case (state)
      S_SQ1:   begin mul_a = dx; mul_b = dx; end
      S_SQ2:   begin mul_a = dy; mul_b = dy; end
      S_M1:    begin mul_a = a;  mul_b = 17'(rotation_cos); end
      S_M2:    begin mul_a = b;  mul_b = 17'(rotation_sin); end
      S_M3:    begin mul_a = a;  mul_b = 17'(rotation_sin); end
      default: begin mul_a = b;  mul_b = 17'(rotation_cos); end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign base_x  = $signed({1'b0, pivot_xy[15:0]}) - $signed({1'b0, box_min_x});
  assign base_y  = $signed({1'b0, pivot_xy[31:16]}) - $signed({1'b0, box_min_y});
  assign acc_mag = acc[35] ? 36'(-acc) : 36'(acc);
  assign out_dvd = acc_mag[32:0] + {18'd0, side[15:1]};
  assign dx_mag  = dx[16] ? 17'(-dx) : 17'(dx);
  assign dy_mag  = dy[16] ? 17'(-dy) : 17'(dy);

  always_comb begin
    dcmd = '0;
    case (state)
      S_SQZ: begin
        dcmd.start     = acc != '0;
        dcmd.sqrt_mode = 1'b1;
        dcmd.steps     = DIV_CNT_W'(31);
        dcmd.operand   = {acc[33:0], 28'd0};
      end
      S_CS: begin
        dcmd.start   = 1'b1;
        dcmd.steps   = DIV_CNT_W'(45);
        dcmd.operand = {({dx_mag, 28'd0} + {14'd0, len[30:1]}), 17'd0};
        dcmd.divisor = {1'b0, len};
      end
      S_SS: begin
        dcmd.start   = 1'b1;
        dcmd.steps   = DIV_CNT_W'(45);
        dcmd.operand = {({dy_mag, 28'd0} + {14'd0, len[30:1]}), 17'd0};
        dcmd.divisor = {1'b0, len};
      end
      S_DXS, S_DYS: begin
        dcmd.start   = 1'b1;
        dcmd.steps   = DIV_CNT_W'(33);
        dcmd.operand = {out_dvd, 29'd0};
        dcmd.divisor = {16'd0, side};
      end
      default: dcmd = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_range && item.command == CMD_READ &&
            {1'b0, item.point_index} < point_count && side_now != 16'd0) begin
          state_next = rotation_ready ? S_PT : S_R51;
        end
      end
      S_R51: state_next = S_R65;
      S_R65: state_next = S_R74;
      S_R74: state_next = S_SQ1;
      S_SQ1: state_next = S_SQ2;
      S_SQ2: state_next = S_SQZ;
      S_SQZ: state_next = (acc == '0) ? S_PT : S_SQW;
      S_SQW: state_next = dstat.done ? S_CS : S_SQW;
      S_CS:  state_next = S_CW;
      S_CW:  state_next = dstat.done ? S_SS : S_CW;
      S_SS:  state_next = S_SW;
      S_SW:  state_next = dstat.done ? S_PT : S_SW;
      S_PT:  state_next = S_PD;
      S_PD:  state_next = S_M1;
      S_M1:  state_next = S_M2;
      S_M2:  state_next = S_DXS;
      S_DXS: state_next = S_DXW;
      S_DXW: state_next = dstat.done ? S_M3 : S_DXW;
      S_M3:  state_next = S_M4;
      S_M4:  state_next = S_DYS;
      S_DYS: state_next = S_DYW;
      S_DYW: state_next = dstat.done ? S_IDLE : S_DYW;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      bbox_count     <= BBOX_COUNT_RST;
      point_count    <= POINT_COUNT_RST;
      box_min_x      <= 16'hffff;
      box_max_x      <= 16'h0000;
      box_min_y      <= 16'hffff;
      box_max_y      <= 16'h0000;
      rotation_cos   <= Q14_ONE;
      rotation_sin   <= 16'sd0;
      pivot_xy       <= 32'd0;
      rotation_ready <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BBOX_COUNT:  bbox_count  <= cfg_data;
          REG_POINT_COUNT: point_count <= cfg_data;
          default: ;
        endcase
      end
      if (we) begin
        rotation_ready <= 1'b0;
        if (widen) begin
          box_min_x <= (item.x_coord < base_min_x) ? item.x_coord : base_min_x;
          box_max_x <= (item.x_coord > base_max_x) ? item.x_coord : base_max_x;
          box_min_y <= (item.y_coord < base_min_y) ? item.y_coord : base_min_y;
          box_max_y <= (item.y_coord > base_max_y) ? item.y_coord : base_max_y;
        end else begin
          box_min_x <= base_min_x;
          box_max_x <= base_max_x;
          box_min_y <= base_min_y;
          box_max_y <= base_max_y;
        end
      end
      if (state == S_IDLE && accept && in_range && item.command == CMD_READ &&
          {1'b0, item.point_index} < point_count && side_now == 16'd0) begin
        done <= 1'b1;
      end
      if (state == S_SQ1) begin
        pivot_xy <= rdata;
      end
      if (state == S_SQZ && acc == '0) begin
        rotation_cos   <= Q14_ONE;
        rotation_sin   <= 16'sd0;
        rotation_ready <= 1'b1;
      end
      if (state == S_CW && dstat.done) begin
        rotation_cos <= dx[16] ? 16'(~dstat.result[15:0] + 16'd1) : dstat.result[15:0];
      end
      if (state == S_SW && dstat.done) begin
        rotation_sin   <= dy[16] ? 16'(~dstat.result[15:0] + 16'd1) : dstat.result[15:0];
        rotation_ready <= 1'b1;
      end
      if (state == S_DYW && dstat.done) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      idx  <= item.point_index;
      side <= side_now;
      result.out_index  <= item.point_index;
      result.out_x      <= 16'sd0;
      result.out_y      <= 16'sd0;
      result.size_error <= 1'b1;
    end
    case (state)
      S_R65: begin
        ea_x <= rdata[15:0];
        ea_y <= rdata[31:16];
      end
      S_R74: begin
        dx <= $signed({1'b0, rdata[15:0]}) - $signed({1'b0, ea_x});
        dy <= $signed({1'b0, ea_y}) - $signed({1'b0, rdata[31:16]});
      end
      S_SQ1: acc <= 36'(prod);
      S_SQ2: acc <= acc + 36'(prod);
      S_SQW: if (dstat.done) len <= dstat.result[30:0];
      S_PD: begin
        a <= $signed({1'b0, rdata[15:0]}) - $signed({1'b0, pivot_xy[15:0]});
        b <= $signed({1'b0, rdata[31:16]}) - $signed({1'b0, pivot_xy[31:16]});
      end
      S_M1:  acc <= 36'($signed({base_x, 14'd0})) + 36'(prod);
      S_M2:  acc <= acc - 36'(prod);
      S_DXS: neg <= acc[35];
      S_DXW: if (dstat.done) res_x <= sat16(neg, dstat.result);
      S_M3:  acc <= 36'($signed({base_y, 14'd0})) + 36'(prod);
      S_M4:  acc <= acc + 36'(prod);
      S_DYS: neg <= acc[35];
      S_DYW: begin
        if (dstat.done) begin
          result.out_index  <= idx;
          result.out_x      <= res_x;
          result.out_y      <= sat16(neg, dstat.result);
          result.size_error <= 1'b0;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    dcmd.start |-> !dstat.busy)
    else $error("divider started while running");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    done && !result.size_error |-> $past(busy))
    else $error("aligned result without a read in progress");

  a_ready_clear_on_load: assert property (@(posedge clk) disable iff (rst)
    $fell(rotation_ready) && !$past(rst) |->
      $past(start && !busy && item.command == CMD_LOAD))
    else $error("rotation dropped without a load");
`endif

endmodule

@@ rtl/flra_ram.sv @@
// ----------------------------------------------------------------------------
// flra_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module flra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/flra_divider.sv @@
// ----------------------------------------------------------------------------
// flra_divider
// Shared restoring unit: unsigned division one quotient bit per cycle, or
// integer square root one root bit per cycle. Operand is left-aligned.
// ----------------------------------------------------------------------------
module flra_divider (
  input  logic                clk,
  input  logic                rst,
  input  flra_pkg::div_cmd_t  cmd,
  output flra_pkg::div_stat_t stat
);
  import flra_pkg::*;

  logic                 run;
  logic                 done;
  logic                 sqrt_mode;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_OP_W-1:0]  opnd;
  logic [DIV_REM_W-1:0] rem;
  logic [DIV_RES_W-1:0] res;
  logic [DIV_DEN_W-1:0] divisor;

  logic [DIV_REM_W-1:0] shin;
  logic [DIV_REM_W-1:0] trial;
  logic                 ge;

  always_comb begin
    if (sqrt_mode) begin
      shin  = {rem[DIV_REM_W-3:0], opnd[DIV_OP_W-1:DIV_OP_W-2]};
      trial = {res[DIV_REM_W-3:0], 2'b01};
    end else begin
      shin  = {rem[DIV_REM_W-2:0], opnd[DIV_OP_W-1]};
      trial = {{(DIV_REM_W-DIV_DEN_W){1'b0}}, divisor};
    end
    ge = shin >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        run <= 1'b1;
      end else if (run && cnt == DIV_CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sqrt_mode <= cmd.sqrt_mode;
      cnt       <= cmd.steps;
      opnd      <= cmd.operand;
      divisor   <= cmd.divisor;
      rem       <= '0;
      res       <= '0;
    end else if (run) begin
      cnt <= cnt - DIV_CNT_W'(1);
      rem <= ge ? shin - trial : shin;
      res <= {res[DIV_RES_W-2:0], ge};
      if (sqrt_mode) begin
        opnd <= {opnd[DIV_OP_W-3:0], 2'b00};
      end else begin
        opnd <= {opnd[DIV_OP_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy   = run;
  assign stat.done   = done;
  assign stat.result = res;

endmodule
